FILE: hdl/hcd_pkg.sv
// Shared types and constants for the header/length/checksum deframer.
package hcd_pkg;

	localparam logic [15:0] HDR_WORD  = 16'hFAFB;
	localparam logic [7:0]  MIN_LEN   = 8'd2;
	localparam logic [15:0] SUM_MASK  = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_done;
		logic       frame_good;
		logic [7:0] payload_count;
	} result_t;

endpackage

FILE: hdl/hcd_step.sv
// Deframer state registers and the per-byte update logic.
module hcd_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       rx_byte,
	output hcd_pkg::result_t res
);

	hcd_pkg::phase_t phase_q, phase_d;
	logic [15:0] recent_q, recent_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  seen_q, seen_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  sumhi_q, sumhi_d;

	logic [7:0]  npay;
	logic [15:0] calc;
	logic [15:0] shifted;

	assign npay    = len_q - hcd_pkg::MIN_LEN;
	assign calc    = (npay[0]) ? (sum_q ^ {8'd0, held_q}) : sum_q;
	assign shifted = {recent_q[7:0], rx_byte};

	// next state
	always_comb begin
		phase_d  = phase_q;
		recent_d = recent_q;
		len_d    = len_q;
		seen_d   = seen_q;
		sum_d    = sum_q;
		held_d   = held_q;
		sumhi_d  = sumhi_q;
		unique case (phase_q)
			hcd_pkg::PH_LEN: begin
				len_d   = rx_byte;
				seen_d  = 8'd0;
				sum_d   = 16'd0;
				held_d  = 8'd0;
				sumhi_d = 8'd0;
				if (rx_byte < hcd_pkg::MIN_LEN) begin
					phase_d  = hcd_pkg::PH_HUNT;
					recent_d = 16'd0;
				end else begin
					phase_d = hcd_pkg::PH_BODY;
				end
			end
			hcd_pkg::PH_BODY: begin
				seen_d = seen_q + 8'd1;
				if (seen_q < npay) begin
					if (!seen_q[0]) begin
						held_d = rx_byte;
					end else begin
						sum_d = (sum_q + {held_q, rx_byte}) & hcd_pkg::SUM_MASK;
					end
				end else if (seen_q == npay) begin
					sumhi_d = rx_byte;
				end else begin
					phase_d  = hcd_pkg::PH_HUNT;
					recent_d = 16'd0;
				end
			end
			default: begin
				// hunting; an unused phase code hunts too
				if (shifted == hcd_pkg::HDR_WORD) begin
					phase_d  = hcd_pkg::PH_LEN;
					recent_d = 16'd0;
				end else begin
					phase_d  = hcd_pkg::PH_HUNT;
					recent_d = shifted;
				end
			end
		endcase
	end

	// result for this byte
	always_comb begin
		res = '0;
		unique case (phase_q)
			hcd_pkg::PH_LEN: begin
				res.frame_done = (rx_byte < hcd_pkg::MIN_LEN);
			end
			hcd_pkg::PH_BODY: begin
				if (seen_q < npay) begin
					res.payload_byte  = rx_byte;
					res.payload_valid = 1'b1;
				end else if (seen_q != npay) begin
					res.frame_done    = 1'b1;
					res.frame_good    = (calc == {sumhi_q, rx_byte});
					res.payload_count = npay;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hcd_pkg::PH_HUNT;
			recent_q <= 16'd0;
			len_q    <= 8'd0;
			seen_q   <= 8'd0;
			sum_q    <= 16'd0;
			held_q   <= 8'd0;
			sumhi_q  <= 8'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			recent_q <= recent_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			sum_q    <= sum_d;
			held_q   <= held_d;
			sumhi_q  <= sumhi_d;
		end
	end

endmodule

FILE: hdl/header_length_checksum_deframer_top.sv
// Top level of the header/length/checksum deframer: input register, step logic, result register.
//
// Deframes a received byte stream. The block hunts for the header 0xFA 0xFB, takes the next
// byte as a length L (payload bytes plus two checksum bytes), passes each of the L-2 payload
// bytes straight out, and after the big-endian checksum reports the frame good or bad with
// the payload count. The checksum is the sum of the payload's big-endian 16-bit words modulo
// 65536, with a trailing odd byte XORed into the low bits. A length below two ends the frame
// at once as bad. Header bytes inside a frame are data: there is no resync and no timeout.
// Every input transaction yields exactly one output transaction. Throughput is one byte per
// clock while the output side does not stall; a byte passes the input register, then the
// result register, and the rate is set by the state update in hcd_step. Both sides use
// valid/stall handshakes; a held result in the output register does not stop the input
// register from taking a new byte while the output side is free.
module header_length_checksum_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic       frame_done,
	output logic       frame_good,
	output logic [7:0] payload_count
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             fire;
	hcd_pkg::result_t res;
	hcd_pkg::result_t res_s2;
	logic             valid_s2;

	// result register empty, or being taken this cycle
	assign out_free = !valid_s2 || !out_stall;
	// byte in stage one moves on when the result register can take it
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	hcd_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_valid = res_s2.payload_valid;
	assign frame_done    = res_s2.frame_done;
	assign frame_good    = res_s2.frame_good;
	assign payload_count = res_s2.payload_count;

endmodule

FILE: bench/deframer_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the deframer bench: byte-level frame predictor and result checker.
package deframer_scoreboard_pkg;

	class deframe_scoreboard;
		hcd_pkg::result_t expected_q[$];
		hcd_pkg::phase_t  phase;
		logic [15:0] hunt_window;
		logic [7:0]  frame_len;
		logic [7:0]  seen;
		logic [15:0] word_sum;
		logic [7:0]  high_byte;
		logic [7:0]  sum_high;
		int unsigned checked;
		int unsigned mismatches;
		int unsigned frames_ended;
		int unsigned frames_good;

		function new();
			phase        = hcd_pkg::PH_HUNT;
			hunt_window  = '0;
			frame_len    = '0;
			seen         = '0;
			word_sum     = '0;
			high_byte    = '0;
			sum_high     = '0;
			checked      = 0;
			mismatches   = 0;
			frames_ended = 0;
			frames_good  = 0;
		endfunction

		// Advance the frame tracker by one accepted byte, queue the result it yields.
		function void note_rx_byte(logic [7:0] b);
			hcd_pkg::result_t r;
			logic [7:0]  npay;
			logic [15:0] calc;
			r = '0;
			case (phase)
				hcd_pkg::PH_LEN: begin
					frame_len = b;
					seen      = '0;
					word_sum  = '0;
					high_byte = '0;
					sum_high  = '0;
					if (b < hcd_pkg::MIN_LEN) begin
						r.frame_done = 1'b1;
						phase        = hcd_pkg::PH_HUNT;
						hunt_window  = '0;
					end else begin
						phase = hcd_pkg::PH_BODY;
					end
				end
				hcd_pkg::PH_BODY: begin
					npay = frame_len - hcd_pkg::MIN_LEN;
					if (seen < npay) begin
						r.payload_byte  = b;
						r.payload_valid = 1'b1;
						if (!seen[0])
							high_byte = b;
						else
							word_sum = word_sum + {high_byte, b};
					end else if (seen == npay) begin
						sum_high = b;
					end else begin
						calc = word_sum;
						if (npay[0])
							calc = calc ^ {8'h00, high_byte};
						r.frame_done    = 1'b1;
						r.frame_good    = (calc == {sum_high, b});
						r.payload_count = npay;
						phase           = hcd_pkg::PH_HUNT;
						hunt_window     = '0;
					end
					seen = seen + 8'd1;
				end
				default: begin
					hunt_window = {hunt_window[7:0], b};
					if (hunt_window == hcd_pkg::HDR_WORD) begin
						phase       = hcd_pkg::PH_LEN;
						hunt_window = '0;
					end else begin
						phase = hcd_pkg::PH_HUNT;
					end
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function string show(hcd_pkg::result_t r);
			return $sformatf("byte=%02h pvalid=%0b done=%0b good=%0b count=%0d",
				r.payload_byte, r.payload_valid, r.frame_done, r.frame_good, r.payload_count);
		endfunction

		function void flag(string why, string want, hcd_pkg::result_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s: expected %s, got %s", $time, why, want, show(got));
		endfunction

		// Compare one accepted output transaction with the oldest prediction.
		function void check_result(hcd_pkg::result_t got);
			hcd_pkg::result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				flag("unexpected transaction", "nothing", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.payload_byte !== want.payload_byte ||
			    got.payload_valid !== want.payload_valid ||
			    got.frame_done !== want.frame_done ||
			    got.frame_good !== want.frame_good ||
			    got.payload_count !== want.payload_count)
				flag("field mismatch", show(want), got);
			if (want.frame_done) begin
				frames_ended++;
				if (want.frame_good)
					frames_good++;
			end
		endfunction
	endclass

endpackage

FILE: bench/header_length_checksum_deframer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the header/length/checksum deframer top level.
module header_length_checksum_deframer_top_tb;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte  = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       frame_done;
	logic       frame_good;
	logic [7:0] payload_count;

	// Idle/stall rates in percent, set per phase by the main sequence.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	// Long receiver hold-off, raised by its own process.
	logic        hold_off      = 1'b0;

	int unsigned bytes_sent    = 0;
	int unsigned framed_bytes  = 0;
	int unsigned frames_sent   = 0;

	deframer_scoreboard_pkg::deframe_scoreboard sb = new();

	// Directed opening: partial and repeated header bytes, both short-length frames,
	// empty frame, odd trailing byte (0x00FF sum) and header bytes used as payload.
	localparam logic [7:0] DIRECTED [26] = '{
		8'h00, 8'hFA, 8'hFA, 8'hFB, 8'h00,
		8'hFA, 8'hFB, 8'h01,
		8'hFA, 8'hFB, 8'h02, 8'h00, 8'h00,
		8'hFA, 8'hFB, 8'h03, 8'hFF, 8'h00, 8'hFF,
		8'hFA, 8'hFB, 8'h04, 8'hFA, 8'hFB, 8'hFA, 8'hFB
	};

	header_length_checksum_deframer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.frame_done    (frame_done),
		.frame_good    (frame_good),
		.payload_count (payload_count)
	);

	always #5 clk = ~clk;

	// Receiver: check accepted transactions, then pick the stall for the next cycle.
	// Everything here reads pre-edge values, so ordering within the step is irrelevant.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{payload_byte, payload_valid, frame_done, frame_good,
				payload_count});
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// Offer one byte, with random idle cycles first; returns once it is accepted.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		sb.note_rx_byte(b);
		bytes_sent++;
	endtask

	// Header, length, random payload and checksum; spoil corrupts the checksum.
	task automatic send_frame(input logic [7:0] len, input bit spoil);
		logic [15:0] sum;
		logic [7:0]  hi;
		logic [7:0]  b;
		int          npay;
		sum = '0;
		hi  = '0;
		frames_sent++;
		send_byte(hcd_pkg::HDR_WORD[15:8]);
		send_byte(hcd_pkg::HDR_WORD[7:0]);
		send_byte(len);
		framed_bytes += 3;
		if (len < hcd_pkg::MIN_LEN)
			return;
		npay = int'(len - hcd_pkg::MIN_LEN);
		for (int i = 0; i < npay; i++) begin
			b = 8'($urandom);
			send_byte(b);
			if (i % 2 == 0)
				hi = b;
			else
				sum = sum + {hi, b};
		end
		if (npay % 2 == 1)
			sum = sum ^ {8'h00, hi};
		if (spoil)
			sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
		send_byte(sum[15:8]);
		send_byte(sum[7:0]);
		framed_bytes += npay + 2;
	endtask

	// Line noise between frames, heavy in first header bytes to tease the hunter.
	task automatic send_noise(input int n);
		repeat (n)
			send_byte($urandom_range(1) ? hcd_pkg::HDR_WORD[15:8] : 8'($urandom));
	endtask

	// Mostly well-formed frames of random content; some bad checksums, bad lengths,
	// empty frames, odd payloads, the occasional near-maximum frame, and noise.
	task automatic run_phase(input int unsigned n_bytes, input int unsigned gap,
	                         input int unsigned stall, input bit open_big);
		int unsigned goal;
		int unsigned r;
		logic [7:0]  len;
		send_idle_pct = gap;
		stall_pct     = stall;
		goal          = framed_bytes + n_bytes;
		if (open_big)
			send_frame(8'd255, 1'($urandom_range(1)));
		while (framed_bytes < goal) begin
			if ($urandom_range(99) < 10)
				send_noise($urandom_range(1, 4));
			r = $urandom_range(99);
			if (r < 1)
				len = 8'($urandom_range(250, 255));
			else if (r < 6)
				len = 8'($urandom_range(1));
			else if (r < 14)
				len = hcd_pkg::MIN_LEN;
			else
				len = 8'($urandom_range(3, 24));
			send_frame(len, $urandom_range(99) < 20);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);

		// Back-pressure: receiver holds off for a long stretch while the sender keeps
		// offering, so the pipeline fills and in_stall has to rise.
		fork
			begin
				hold_off <= 1'b1;
				repeat (150) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none

		run_phase(400, 0, 0, 1'b1);
		run_phase(400, 46, 0, 1'b0);
		run_phase(400, 0, 46, 1'b1);
		run_phase(400, 16, 16, 1'b0);

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d input bytes in %0d frames plus noise; %0d results checked.",
			bytes_sent, frames_sent, sb.checked);
		$display("%0d frames ended (%0d good), %0d mismatches.",
			sb.frames_ended, sb.frames_good, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legitimate run.
	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding.", sb.expected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
